// ===== src/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// tws_pkg: shared types and helpers for the tournament winner selector
// Fitness rounding and ordering, register indexes, widths.
// ----------------------------------------------------------------------------
package tws_pkg;

	localparam int MaxPopulation = 1024;
	localparam int MantissaKeep  = 40;
	localparam int CfgW          = 11;
	localparam int IdxW          = 10;
	localparam int FitW          = 64;
	localparam int KeyW          = 64;

	localparam logic [1:0] REG_POPULATION = 2'd0;
	localparam logic [1:0] REG_PRESSURE   = 2'd1;
	localparam logic [1:0] REG_COUNT      = 2'd2;

	typedef struct packed {
		logic [CfgW-1:0] pop;
		logic [CfgW-1:0] tsize;
		logic [CfgW-1:0] count;
	} tws_cfg_t;

	function automatic logic fit_is_nan(input logic [63:0] b);
		return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
	endfunction

	// round magnitude to MantissaKeep significant bits, half away from zero
	function automatic logic [63:0] fit_round(input logic [63:0] b);
		logic [62:0] mag;
		logic [62:0] sum;
		logic [63:0] res;
		int          sig;
		int          drop;
		mag  = b[62:0];
		res  = b;
		sig  = 53;
		if (b[62:52] == 11'h000) begin
			sig = 0;
			for (int i = 0; i < 52; i++)
				if (mag[i]) sig = i + 1;
		end
		if (b[62:52] != 11'h7FF) begin
			if (mag == 63'd0) begin
				res = 64'd0;
			end else if (sig > MantissaKeep) begin
				drop = sig - MantissaKeep;
				sum  = mag + (63'd1 << (drop - 1));
				sum  = sum & ~((63'd1 << drop) - 63'd1);
				res  = {b[63], sum};
			end
		end
		return res;
	endfunction

	function automatic logic [63:0] fit_order(input logic [63:0] b);
		return b[63] ? ~b : {1'b1, b[62:0]};
	endfunction

endpackage

// ===== src/tws_if.sv =====
// ----------------------------------------------------------------------------
// tws_if: valid/ready channel interfaces
// Member, winner and config channels.
// ----------------------------------------------------------------------------
interface tws_member_if;
	import tws_pkg::*;
	logic            valid;
	logic            ready;
	logic [IdxW-1:0] member_index;
	logic [FitW-1:0] fitness_bits;
	logic [KeyW-1:0] tie_key;
	modport source (output valid, member_index, fitness_bits, tie_key, input ready);
	modport sink   (input valid, member_index, fitness_bits, tie_key, output ready);
endinterface

interface tws_winner_if;
	import tws_pkg::*;
	logic            valid;
	logic            ready;
	logic [IdxW-1:0] win_idx;
	logic            last_winner;
	modport source (output valid, win_idx, last_winner, input ready);
	modport sink   (input valid, win_idx, last_winner, output ready);
endinterface

interface tws_cfg_if;
	import tws_pkg::*;
	logic            valid;
	logic            ready;
	logic [1:0]      index;
	logic [CfgW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/tws_cfg.sv =====
// ----------------------------------------------------------------------------
// tws_cfg: configuration registers
// Holds the registers, derives clamped population and tournament size.
// ----------------------------------------------------------------------------
module tws_cfg import tws_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  logic [1:0] wr_index,
	input  logic [CfgW-1:0] wr_data,
	output logic     restart,
	output tws_cfg_t cfg
);
	logic [CfgW-1:0] pop_q, pres_q, count_q;
	logic [CfgW-1:0] pop_c, ts_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_q   <= CfgW'(1);
			pres_q  <= CfgW'(2);
			count_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_POPULATION: pop_q   <= wr_data;
				REG_PRESSURE:   pres_q  <= wr_data;
				REG_COUNT:      count_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign restart = wr_en && (wr_index == REG_POPULATION || wr_index == REG_PRESSURE ||
		wr_index == REG_COUNT);

	always_comb begin
		pop_c = pop_q;
		if (pop_q == '0) pop_c = CfgW'(1);
		if (pop_q > CfgW'(MaxPopulation)) pop_c = CfgW'(MaxPopulation);
		ts_c = (pres_q < pop_c) ? pres_q : pop_c;
		if (ts_c == '0) ts_c = CfgW'(1);
	end

	assign cfg = '{pop: pop_c, tsize: ts_c, count: count_q};
endmodule

// ===== src/tws_core.sv =====
// ----------------------------------------------------------------------------
// tws_core: tournament compare and count
// Input register, rounding plus compare against running best, result register.
// ----------------------------------------------------------------------------
module tws_core import tws_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     restart,
	input  tws_cfg_t cfg,
	tws_member_if.sink  m,
	tws_winner_if.source w
);
	logic            v_s1;
	logic [IdxW-1:0] idx_s1;
	logic [FitW-1:0] fit_s1;
	logic [KeyW-1:0] key_s1;

	logic [CfgW-1:0] pass_q, chunk_q, emitted_q;
	logic            fin_q;
	logic [IdxW-1:0] bmem_q;
	logic [FitW-1:0] bfit_q;
	logic [KeyW-1:0] bkey_q;

	logic            ov_q;
	logic [IdxW-1:0] oidx_q;
	logic            olast_q;

	logic            stall, s1_ready;
	logic [FitW-1:0] fit_r;
	logic            take, close, done_now, last;
	logic [CfgW-1:0] chunk_n, pass_n, emit_n;

	// stage 1 may advance unless it would produce an item into a full output
	assign stall    = ov_q && !w.ready && v_s1 && close && !done_now;
	assign s1_ready = !stall;
	assign m.ready  = s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (restart) v_s1 <= 1'b0;
		else if (s1_ready) v_s1 <= m.valid;
	end
	always_ff @(posedge clk) begin
		if (s1_ready && m.valid) begin
			idx_s1 <= m.member_index;
			fit_s1 <= m.fitness_bits;
			key_s1 <= m.tie_key;
		end
	end

	always_comb begin
		fit_r    = fit_round(fit_s1);
		done_now = fin_q || (emitted_q >= cfg.count);
		if (chunk_q == '0) take = 1'b1;
		else if (fit_is_nan(fit_r) || fit_is_nan(bfit_q)) take = 1'b0;
		else if (fit_r != bfit_q) take = fit_order(fit_r) > fit_order(bfit_q);
		else take = key_s1 < bkey_q;
		chunk_n = chunk_q + CfgW'(1);
		pass_n  = pass_q + CfgW'(1);
		close   = (chunk_n >= cfg.tsize) || (pass_n >= cfg.pop);
		emit_n  = emitted_q + CfgW'(1);
		last    = emit_n >= cfg.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= '0; chunk_q <= '0; emitted_q <= '0; fin_q <= 1'b0;
			bmem_q <= '0; bfit_q <= '0; bkey_q <= '0;
		end else if (restart) begin
			pass_q <= '0; chunk_q <= '0; emitted_q <= '0; fin_q <= 1'b0;
			bmem_q <= '0; bfit_q <= '0; bkey_q <= '0;
		end else if (v_s1 && !stall) begin
			if (done_now) begin
				fin_q <= 1'b1;
			end else begin
				if (take) begin
					bmem_q <= idx_s1; bfit_q <= fit_r; bkey_q <= key_s1;
				end
				if (close) begin
					chunk_q   <= '0;
					pass_q    <= (pass_n >= cfg.pop) ? '0 : pass_n;
					emitted_q <= emit_n;
					if (last) fin_q <= 1'b1;
				end else begin
					chunk_q <= chunk_n;
					pass_q  <= pass_n;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (v_s1 && !stall && close && !done_now) ov_q <= 1'b1;
		else if (w.ready) ov_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (v_s1 && !stall && close && !done_now) begin
			oidx_q  <= take ? idx_s1 : bmem_q;
			olast_q <= last;
		end
	end

	assign w.valid       = ov_q;
	assign w.win_idx     = oidx_q;
	assign w.last_winner = olast_q;

	a_fin_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q && !restart |=> !(ov_q && !$past(ov_q)))
		else $error("winner after selection finished");
	a_chunk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_q < cfg.tsize || restart)
		else $error("tournament position out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !w.ready |=> ov_q)
		else $error("winner dropped while stalled");
endmodule

// ===== src/tournament_winner_selector.sv =====
// ----------------------------------------------------------------------------
// tournament_winner_selector: tournament selection without replacement
// Picks one winner per tournament of shuffled population members.
// ----------------------------------------------------------------------------
// Usage:
//   member channel: one member item per accepted handshake (index, fitness,
//   key), in shuffled order. winner channel: one item per closed tournament,
//   last_winner set on the item that completes the requested winner count.
//   cfg channel: index 0 population, 1 pressure (tournament size),
//   2 winner count; any listed write restarts selection. Write only idle.
// Throughput: one member per cycle unless a closing member is stalled (see
//   Stall). A winner passes from the member that closes its tournament
//   through the input register, round-and-compare logic and output register.
// Reset: population 1, pressure 2, count 0, so members are ignored until
//   the winner count is written.
// Stall: the output register holds a winner until taken; members that do
//   not close a tournament still flow, a closing member waits in stage one.
// ----------------------------------------------------------------------------
module tournament_winner_selector import tws_pkg::*; (
	input logic clk,
	input logic arst_n,
	tws_member_if.sink   member,
	tws_winner_if.source winner,
	tws_cfg_if.sink      cfg_wr
);
	tws_cfg_t cfg;
	logic     restart;

	assign cfg_wr.ready = 1'b1;

	tws_cfg u_cfg (
		.clk(clk), .arst_n(arst_n),
		.wr_en(cfg_wr.valid), .wr_index(cfg_wr.index), .wr_data(cfg_wr.data),
		.restart(restart), .cfg(cfg)
	);

	tws_core u_core (
		.clk(clk), .arst_n(arst_n), .restart(restart), .cfg(cfg),
		.m(member), .w(winner)
	);
endmodule
